// ===== sv/sliding_window_mean_variance_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SLIDING_WINDOW_MEAN_VARIANCE_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MEAN_VARIANCE_CORE_ASSERT_SVH

// Clocked property, off while reset is high.
`define SWMV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("swmv check failed");

// Clocked property that also holds around reset.
`define SWMV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("swmv check failed");

`endif

// ===== sv/swmv_pkg.sv =====
`timescale 1ns / 1ps
package swmv_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;

  localparam int WIN_LOG      = $clog2(MAX_WINDOW);
  localparam int SLOT_BITS    = WIN_LOG;
  localparam int LEN_BITS     = 9;
  localparam int CNT_BITS     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS     = SAMPLE_BITS + WIN_LOG + 1;
  localparam int MAG_BITS     = SAMPLE_BITS + WIN_LOG;
  localparam int SQ1_BITS     = 2 * SAMPLE_BITS - 1;
  localparam int SQSUM_BITS   = SQ1_BITS + WIN_LOG;
  localparam int MEAN_BITS    = 24;
  localparam int MSQ_BITS     = 39;
  localparam int PROD_BITS    = SQSUM_BITS + WIN_LOG;
  localparam int DIV_BITS     = PROD_BITS + FRAC_BITS;
  localparam int DIVISOR_BITS = 2 * WIN_LOG + 1;
  localparam int STEP_BITS    = $clog2(DIV_BITS + 1);
  localparam int MEAN_DIV_BITS = MAG_BITS + FRAC_BITS;
  localparam int MSQ_DIV_BITS  = SQSUM_BITS + FRAC_BITS;

  localparam logic [LEN_BITS-1:0] WINDOW_LENGTH_RESET = LEN_BITS'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_MULT,
    ST_DIV_MEAN,
    ST_DIV_MSQ,
    ST_DIV_VAR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                    start;
    logic [STEP_BITS-1:0]    steps;
    logic [DIV_BITS-1:0]     dividend;
    logic [DIVISOR_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/swmv_in_if.sv =====
`timescale 1ns / 1ps
interface swmv_in_if;
  import swmv_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

// ===== sv/swmv_out_if.sv =====
`timescale 1ns / 1ps
interface swmv_out_if;
  import swmv_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [MEAN_BITS-1:0] mean;
  logic [MSQ_BITS-1:0]         mean_square;
  logic [MSQ_BITS-1:0]         variance;
  logic                        window_full;

  modport source (output valid, output mean, output mean_square, output variance,
                  output window_full, input ready);
  modport sink (input valid, input mean, input mean_square, input variance,
                input window_full, output ready);
endinterface

// ===== sv/swmv_cfg_if.sv =====
`timescale 1ns / 1ps
interface swmv_cfg_if;
  import swmv_pkg::*;

  logic                valid;
  logic                ready;
  logic [LEN_BITS-1:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

// ===== sv/swmv_ram.sv =====
`timescale 1ns / 1ps
module swmv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/swmv_div.sv =====
`timescale 1ns / 1ps
module swmv_div (
  input  logic               clk,
  input  logic               rst,
  input  swmv_pkg::div_req_t req,
  output swmv_pkg::div_rsp_t rsp
);
  import swmv_pkg::*;

  // Restoring division, one quotient bit per cycle. The dividend arrives
  // left aligned; after "steps" shifts the quotient fills the low bits.
  logic [DIV_BITS-1:0]     dq;
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS-1:0] divisor;
  logic [STEP_BITS-1:0]    cnt;
  logic                    busy;
  logic                    done;

  logic [DIVISOR_BITS:0]   trial;
  logic [DIVISOR_BITS:0]   diff;
  logic                    take;

  always_comb begin
    trial = {rem, dq[DIV_BITS-1]};
    diff  = trial - {1'b0, divisor};
    take  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= req.steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == STEP_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq      <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      dq  <= {dq[DIV_BITS-2:0], take};
      rem <= take ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

// ===== sv/sliding_window_mean_variance_core.sv =====
`timescale 1ns / 1ps
// Sliding-window mean, mean of squares and variance of a signed sample stream.
// Channels: samples (sample, restart) in, results (mean, mean_square,
// variance, window_full) out, cfg (window_length) for the one register.
// Each result value carries 8 fraction bits and is truncated toward zero.
// A word on samples is taken only while the core is idle; it is then worked
// through the steps below before its result word shows on results, and no new
// sample word is taken before the core is through with the last one. The shared
// restoring divider resolves one quotient bit per cycle: 32 quotient bits for
// the mean, 47 for the mean of squares, 55 for the variance. Around it lie the
// delay-line read, sum update, three divider loads (the first also latches the
// products), quotient capture, output load and the idle state that takes the
// next word.
// The result sits in an output register, so a stalled receiver holds only
// that word; the core still takes and works the next sample, and waits at
// the end of that item until the output register frees.
// Reset (rst, synchronous) empties the window, sets window_length to 16 and
// drops any word in flight. Restart on a sample word, or any cfg write,
// empties the window. The delay line needs no clearing pass: only slots
// written since the window last emptied are ever read back.
module sliding_window_mean_variance_core (
  input  logic       clk,
  input  logic       rst,
  swmv_in_if.sink    samples,
  swmv_out_if.source results,
  swmv_cfg_if.sink   cfg
);
  import swmv_pkg::*;

  state_t state;
  state_t state_next;

  // Stream state.
  logic [LEN_BITS-1:0]          window_length;
  logic [SLOT_BITS-1:0]         write_slot;
  logic [CNT_BITS-1:0]          samples_seen;
  logic signed [SUM_BITS-1:0]   window_sum;
  logic [SQSUM_BITS-1:0]        square_sum;

  // Per-item working registers.
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [SQ1_BITS-1:0]           sample_sq;
  logic                          evict;
  logic [PROD_BITS-1:0]          n_sq;
  logic [PROD_BITS-1:0]          mag_sq;
  logic [DIVISOR_BITS-1:0]       n_n;
  logic                          neg;
  logic                          full;
  logic [MEAN_BITS-1:0]          mean_q;
  logic [MSQ_BITS-1:0]           msq_q;
  logic [MSQ_BITS-1:0]           var_q;

  // Control outputs.
  logic in_ready;
  logic ram_re;
  logic ram_we;
  logic out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CNT_BITS-1:0]           eff_len;
  logic [CNT_BITS:0]             slot_w;
  logic [CNT_BITS:0]             len_w;
  logic [CNT_BITS:0]             back_w;
  logic [SLOT_BITS-1:0]          rd_addr;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic signed [SAMPLE_BITS-1:0] old;
  logic [SUM_BITS-1:0]           neg_sum;
  logic [MAG_BITS-1:0]           mag;
  logic [2*CNT_BITS-1:0]         n_n_full;

  logic signed [SUM_BITS-1:0]    window_sum_next;
  logic [SQSUM_BITS-1:0]         square_sum_next;
  logic [SQ1_BITS-1:0]           old_sq;
  logic signed [2*SAMPLE_BITS-1:0] old_prod;

  // Zero length counts as one, anything past the delay line saturates.
  always_comb begin
    if (window_length == '0) begin
      eff_len = CNT_BITS'(1);
    end else if (window_length > LEN_BITS'(MAX_WINDOW)) begin
      eff_len = CNT_BITS'(MAX_WINDOW);
    end else begin
      eff_len = CNT_BITS'(window_length);
    end
  end

  // Slot of the oldest sample: write_slot - len, wrapped over the delay line.
  always_comb begin
    slot_w = (CNT_BITS + 1)'(write_slot);
    len_w  = (CNT_BITS + 1)'(eff_len);
    if (slot_w >= len_w) begin
      back_w = slot_w - len_w;
    end else begin
      back_w = slot_w + (CNT_BITS + 1)'(MAX_WINDOW) - len_w;
    end
    rd_addr = back_w[SLOT_BITS-1:0];
  end

  swmv_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (sample),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Drop the leaving sample (if the window is full) and add the new one.
  always_comb begin
    old      = $signed(rd_data);
    old_prod = old * old;
    old_sq   = old_prod[SQ1_BITS-1:0];
    window_sum_next = window_sum + SUM_BITS'(sample);
    square_sum_next = square_sum + SQSUM_BITS'(sample_sq);
    if (evict) begin
      window_sum_next = window_sum_next - SUM_BITS'(old);
      square_sum_next = square_sum_next - SQSUM_BITS'(old_sq);
    end
  end

  always_comb begin
    neg_sum  = -window_sum;
    mag      = window_sum[SUM_BITS-1] ? neg_sum[MAG_BITS-1:0] : window_sum[MAG_BITS-1:0];
    n_n_full = samples_seen * samples_seen;
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (samples.valid) state_next = ST_READ;
      ST_READ:     state_next = ST_UPDATE;
      ST_UPDATE:   state_next = ST_MULT;
      ST_MULT:     state_next = ST_DIV_MEAN;
      ST_DIV_MEAN: if (div_rsp.done) state_next = ST_DIV_MSQ;
      ST_DIV_MSQ:  if (div_rsp.done) state_next = ST_DIV_VAR;
      ST_DIV_VAR:  if (div_rsp.done) state_next = ST_FINISH;
      ST_FINISH:   if (!results.valid || results.ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer: control outputs and divider requests.
  always_comb begin
    in_ready         = 1'b0;
    ram_re           = 1'b0;
    ram_we           = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.steps    = STEP_BITS'(MEAN_DIV_BITS);
    div_req.dividend = DIV_BITS'({mag, {FRAC_BITS{1'b0}}}) << (DIV_BITS - MEAN_DIV_BITS);
    div_req.divisor  = DIVISOR_BITS'(samples_seen);
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_READ:   ram_re = 1'b1;
      ST_UPDATE: ram_we = 1'b1;
      ST_MULT:   div_req.start = 1'b1;
      ST_DIV_MEAN: begin
        div_req.start    = div_rsp.done;
        div_req.steps    = STEP_BITS'(MSQ_DIV_BITS);
        div_req.dividend = DIV_BITS'({square_sum, {FRAC_BITS{1'b0}}})
                           << (DIV_BITS - MSQ_DIV_BITS);
      end
      ST_DIV_MSQ: begin
        div_req.start    = div_rsp.done;
        div_req.steps    = STEP_BITS'(DIV_BITS);
        div_req.dividend = {n_sq - mag_sq, {FRAC_BITS{1'b0}}};
        div_req.divisor  = n_n;
      end
      ST_DIV_VAR: ;
      ST_FINISH:  out_load = !results.valid || results.ready;
      default: ;
    endcase
  end

  swmv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign samples.ready = in_ready;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Stream state: cfg writes and restart empty the window.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
      write_slot    <= '0;
      samples_seen  <= '0;
      window_sum    <= '0;
      square_sum    <= '0;
    end else if (cfg.valid) begin
      window_length <= cfg.window_length;
      write_slot    <= '0;
      samples_seen  <= '0;
      window_sum    <= '0;
      square_sum    <= '0;
    end else if (samples.valid && in_ready && samples.restart) begin
      write_slot    <= '0;
      samples_seen  <= '0;
      window_sum    <= '0;
      square_sum    <= '0;
    end else if (state == ST_UPDATE) begin
      window_sum   <= window_sum_next;
      square_sum   <= square_sum_next;
      samples_seen <= evict ? eff_len : samples_seen + 1'b1;
      write_slot   <= (write_slot == SLOT_BITS'(MAX_WINDOW - 1)) ? '0 : write_slot + 1'b1;
    end
  end

  // Per-item datapath registers.
  always_ff @(posedge clk) begin
    if (samples.valid && in_ready) begin
      sample <= samples.sample;
    end
    if (state == ST_READ) begin
      sample_sq <= SQ1_BITS'(sample * sample);
      evict     <= samples_seen >= eff_len;
    end
    if (state == ST_MULT) begin
      n_sq   <= PROD_BITS'(samples_seen * square_sum);
      mag_sq <= PROD_BITS'(mag * mag);
      n_n    <= n_n_full[DIVISOR_BITS-1:0];
      neg    <= window_sum[SUM_BITS-1];
      full   <= samples_seen == eff_len;
    end
    if (state == ST_DIV_MEAN && div_rsp.done) begin
      mean_q <= div_rsp.quotient[MEAN_BITS-1:0];
    end
    if (state == ST_DIV_MSQ && div_rsp.done) begin
      msq_q <= div_rsp.quotient[MSQ_BITS-1:0];
    end
    if (state == ST_DIV_VAR && div_rsp.done) begin
      var_q <= div_rsp.quotient[MSQ_BITS-1:0];
    end
  end

  // Output register: hold the word until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.mean        <= neg ? -$signed(mean_q) : $signed(mean_q);
      results.mean_square <= msq_q;
      results.variance    <= var_q;
      results.window_full <= full;
    end
  end

endmodule

// ===== sv/swmv_checker.sv =====
`timescale 1ns / 1ps
`include "sliding_window_mean_variance_core_assert.svh"
module swmv_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [swmv_pkg::MEAN_BITS-1:0] mean,
  input logic [swmv_pkg::MSQ_BITS-1:0]         mean_square,
  input logic [swmv_pkg::MSQ_BITS-1:0]         variance
);

  // One sample at a time: busy right after taking a word.
  `SWMV_ASSERT(a_busy_after_accept, clk, rst, in_valid && in_ready |=> !in_ready)

  // Variance never exceeds the mean of squares.
  `SWMV_ASSERT(a_var_below_msq, clk, rst, out_valid |-> variance <= mean_square)

  // A stalled result word holds its mean and variance.
  `SWMV_ASSERT(a_stall_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(mean) && $stable(variance))

  // Reset leaves the core idle and the output empty.
  `SWMV_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> in_ready && !out_valid)

endmodule

bind sliding_window_mean_variance_core swmv_checker u_swmv_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .mean        (results.mean),
  .mean_square (results.mean_square),
  .variance    (results.variance)
);
